[design/dtps_pkg.sv]
// Shared constants, widths and the quarter-wave sine table of the pitch shifter.
package dtps_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int STORE_DEPTH   = 16384;
  localparam int ADDR_BITS     = $clog2(STORE_DEPTH);
  localparam int PH_BITS       = 24;
  localparam int SPAN_BITS     = ADDR_BITS + 1;
  localparam int SPAN_IN_BITS  = 15;
  localparam int GAIN_BITS     = 17;
  localparam int TAB_BITS      = 16;
  localparam int GFR_BITS      = 19;
  localparam int DATA_BITS     = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  localparam int MUL_A_BITS = (SAMPLE_BITS + 2 > PH_BITS + 2) ? SAMPLE_BITS + 2 : PH_BITS + 2;
  localparam int MUL_B_BITS = PH_BITS + 1;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
  localparam int DLY_BITS   = PH_BITS + 1 + SPAN_BITS;
  localparam int RP_BITS    = ADDR_BITS + PH_BITS;
  localparam int SC_BITS    = PROD_BITS + 1;
  localparam int ACC_BITS   = PROD_BITS + 1;
  localparam int OUT_SHIFT  = 15;

  localparam logic [DLY_BITS-1:0] DLY_MAX = DLY_BITS'(STORE_DEPTH - 2) << PH_BITS;
  localparam logic [PH_BITS:0]    PH_ONE  = (PH_BITS + 1)'(1) << PH_BITS;
  localparam logic [SPAN_BITS-1:0] SPAN_MIN   = SPAN_BITS'(64);
  localparam logic [SPAN_BITS-1:0] SPAN_MAX   = SPAN_BITS'(STORE_DEPTH);
  localparam logic [SPAN_BITS-1:0] SPAN_RESET = SPAN_BITS'(8192);
  localparam logic [PH_BITS-1:0]   PH_HALF    = PH_BITS'(1) << (PH_BITS - 1);
  localparam logic [GAIN_BITS-1:0] GAIN_FULL  = GAIN_BITS'(32768);

  localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_INC = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_PITCH_UP  = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_SPAN      = CFG_IDX_BITS'(2);

  function automatic logic [TAB_BITS-1:0] quarter_sine(input logic [4:0] k);
    logic [TAB_BITS-1:0] v;
    case (k)
      5'd0:  v = 16'd0;
      5'd1:  v = 16'd3212;
      5'd2:  v = 16'd6393;
      5'd3:  v = 16'd9512;
      5'd4:  v = 16'd12540;
      5'd5:  v = 16'd15447;
      5'd6:  v = 16'd18205;
      5'd7:  v = 16'd20788;
      5'd8:  v = 16'd23170;
      5'd9:  v = 16'd25330;
      5'd10: v = 16'd27246;
      5'd11: v = 16'd28899;
      5'd12: v = 16'd30274;
      5'd13: v = 16'd31357;
      5'd14: v = 16'd32138;
      5'd15: v = 16'd32610;
      5'd16: v = 16'd32768;
      default: v = 16'd32768;
    endcase
    return v;
  endfunction

endpackage

[design/dtps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dtps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[design/dual_tap_delay_pitch_shifter.sv]
// Top level: dual-tap delay-line pitch shifter with sine-windowed crossfade.
// Each request is taken only in the idle state and runs to a registered result before the
// next request is accepted; the result can stall on output back-pressure.
// The sequence is set by one shared multiplier used four times per tap, two taps.
// Reset restores the config, phases, state and fill count; unwritten store entries read as zero.
module dual_tap_delay_pitch_shifter import dtps_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [DATA_BITS-1:0]     s_tdata,   // in_sample
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [DATA_BITS-1:0]     m_tdata    // shifted sample
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DMUL, ST_ADDR, ST_RD0, ST_RD1, ST_RD2,
    ST_IMUL, ST_GMUL, ST_WMUL, ST_OUT
  } state_t;

  state_t state;

  logic [PH_BITS-1:0]   phase_increment;
  logic                 pitch_up;
  logic [SPAN_BITS-1:0] delay_span;
  logic [ADDR_BITS-1:0] wr_pos;
  logic [ADDR_BITS:0]   fill;
  logic [PH_BITS-1:0]   phase_first;
  logic [PH_BITS-1:0]   phase_second;
  logic                 tap_sel;
  logic [DLY_BITS-1:0]  dly;
  logic [ADDR_BITS-1:0] rd_idx;
  logic [PH_BITS-1:0]   frac;
  logic [PH_BITS-1:0]   gq;
  logic signed [SAMPLE_BITS-1:0] s0;
  logic signed [SAMPLE_BITS-1:0] s1;
  logic signed [SAMPLE_BITS:0]   interp;
  logic [GAIN_BITS-1:0]          gain;
  logic signed [ACC_BITS-1:0]    acc;
  logic [SAMPLE_BITS-1:0]        out_q;

  logic [PH_BITS-1:0]   cur_phase;
  logic [PH_BITS:0]     ph_eff;
  logic [DLY_BITS-1:0]  dly_cl;
  logic [RP_BITS-1:0]   rp;
  logic [ADDR_BITS-1:0] rd_idx_nx;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic signed [SAMPLE_BITS:0]   diff;
  logic [4:0]           gidx;
  logic [TAB_BITS-1:0]  tab_a;
  logic [TAB_BITS-1:0]  tab_b;
  logic signed [MUL_A_BITS-1:0] mul_a;
  logic signed [MUL_B_BITS-1:0] mul_b;
  logic signed [PROD_BITS-1:0]  prod;
  logic signed [SC_BITS-1:0]    scaled;
  logic signed [ACC_BITS-1:0]   acc_r;
  logic signed [ACC_BITS-1:0]   y_big;
  logic [SAMPLE_BITS-1:0]       y_sat;
  logic [SPAN_IN_BITS-1:0]      span_in;
  logic [SPAN_BITS-1:0]         span_cl;
  logic                         accept;

  localparam logic signed [ACC_BITS-1:0] Y_MAX = ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_BITS-1:0] Y_MIN = -ACC_BITS'(64'sd1 <<< (SAMPLE_BITS - 1));
  localparam logic [SC_BITS-1:0]  SC_ROUND = SC_BITS'(1) << (PH_BITS - 1);
  localparam logic [ACC_BITS-1:0] Y_ROUND  = ACC_BITS'(1) << (OUT_SHIFT - 1);

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign m_tdata   = DATA_BITS'(out_q);

  assign cur_phase = tap_sel ? phase_second : phase_first;
  assign ph_eff    = pitch_up ? (PH_ONE - {1'b0, cur_phase}) : {1'b0, cur_phase};
  assign dly_cl    = (dly > DLY_MAX) ? DLY_MAX : dly;
  assign rp        = {wr_pos, {PH_BITS{1'b0}}} - dly_cl[RP_BITS-1:0];
  assign rd_idx_nx = rd_idx + ADDR_BITS'(1);
  assign rd_addr   = (state == ST_RD1) ? rd_idx_nx : rd_idx;
  assign diff      = {s1[SAMPLE_BITS-1], s1} - {s0[SAMPLE_BITS-1], s0};
  assign gidx      = gq[PH_BITS-1:GFR_BITS];
  assign tab_a     = quarter_sine(gidx);
  assign tab_b     = quarter_sine(gidx + 5'd1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_DMUL: begin
        mul_a = MUL_A_BITS'(ph_eff);
        mul_b = MUL_B_BITS'(delay_span - SPAN_BITS'(1));
      end
      ST_IMUL: begin
        mul_a = MUL_A_BITS'(diff);
        mul_b = MUL_B_BITS'(frac);
      end
      ST_GMUL: begin
        mul_a = MUL_A_BITS'(tab_b - tab_a);
        mul_b = MUL_B_BITS'(gq[GFR_BITS-1:0]);
      end
      ST_WMUL: begin
        mul_a = MUL_A_BITS'(interp);
        mul_b = MUL_B_BITS'(gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign scaled = (SC_BITS'(s0) <<< PH_BITS) + SC_BITS'(prod) + SC_ROUND;
  assign acc_r  = acc + Y_ROUND;
  assign y_big  = acc_r >>> OUT_SHIFT;
  assign y_sat  = (y_big > Y_MAX) ? Y_MAX[SAMPLE_BITS-1:0] :
                  (y_big < Y_MIN) ? Y_MIN[SAMPLE_BITS-1:0] : y_big[SAMPLE_BITS-1:0];

  assign span_in = cfg_data[SPAN_IN_BITS-1:0];
  always_comb begin
    if (SPAN_BITS'(span_in) < SPAN_MIN) begin
      span_cl = SPAN_MIN;
    end else if ((SPAN_BITS + SPAN_IN_BITS)'(span_in) > (SPAN_BITS + SPAN_IN_BITS)'(SPAN_MAX)) begin
      span_cl = SPAN_MAX;
    end else begin
      span_cl = SPAN_BITS'(span_in);
    end
  end

  dtps_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wr_pos),
    .wr_data (s_tdata[SAMPLE_BITS-1:0]),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      phase_increment <= '0;
      pitch_up        <= 1'b1;
      delay_span      <= SPAN_RESET;
      wr_pos          <= '0;
      fill            <= '0;
      phase_first     <= '0;
      phase_second    <= PH_HALF;
      tap_sel         <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PHASE_INC: phase_increment <= cfg_data[PH_BITS-1:0];
          REG_PITCH_UP:  pitch_up        <= cfg_data[0];
          REG_SPAN:      delay_span      <= span_cl;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            phase_first  <= phase_first + phase_increment;
            phase_second <= phase_second + phase_increment;
            if (fill != (ADDR_BITS + 1)'(STORE_DEPTH)) begin
              fill <= fill + (ADDR_BITS + 1)'(1);
            end
            acc     <= '0;
            tap_sel <= 1'b0;
            state   <= ST_DMUL;
          end
        end
        ST_DMUL: begin
          dly   <= prod[DLY_BITS-1:0];
          state <= ST_ADDR;
        end
        ST_ADDR: begin
          rd_idx <= rp[RP_BITS-1:PH_BITS];
          frac   <= rp[PH_BITS-1:0];
          gq     <= cur_phase[PH_BITS-1] ? PH_BITS'(PH_ONE - {1'b0, cur_phase}) : cur_phase;
          state  <= ST_RD0;
        end
        ST_RD0: begin
          state <= ST_RD1;
        end
        ST_RD1: begin
          s0    <= ({1'b0, rd_idx} < fill) ? rd_data : '0;
          state <= ST_RD2;
        end
        ST_RD2: begin
          s1    <= ({1'b0, rd_idx_nx} < fill) ? rd_data : '0;
          state <= ST_IMUL;
        end
        ST_IMUL: begin
          interp <= scaled[SAMPLE_BITS+PH_BITS:PH_BITS];
          state  <= ST_GMUL;
        end
        ST_GMUL: begin
          if (gidx >= 5'd16) begin
            gain <= GAIN_FULL;
          end else begin
            gain <= GAIN_BITS'(tab_a) + GAIN_BITS'(prod[GFR_BITS+TAB_BITS-1:GFR_BITS]);
          end
          state <= ST_WMUL;
        end
        ST_WMUL: begin
          acc <= acc + ACC_BITS'(prod);
          if (tap_sel) begin
            state <= ST_OUT;
          end else begin
            tap_sel <= 1'b1;
            state   <= ST_DMUL;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            out_q    <= y_sat;
            m_tvalid <= 1'b1;
            wr_pos   <= wr_pos + ADDR_BITS'(1);
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[sim/dual_tap_delay_pitch_shifter_tb.sv]
// Self-checking testbench for the dual-tap delay-line pitch shifter.
module dual_tap_delay_pitch_shifter_tb import dtps_pkg::*; ();

  localparam int CYCLE_LIMIT = 400000;
  localparam int DEPTH = 16384;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = CFG_IDX_BITS'(3);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DATA_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [DATA_BITS-1:0] m_tdata;

  dual_tap_delay_pitch_shifter dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic signed [23:0] echo_store [DEPTH];
  logic [13:0] wr_pos;
  logic [23:0] ph_a, ph_b, ph_step;
  logic        up_mode;
  logic [14:0] span;

  logic [23:0] pending_samples [$];
  logic [23:0] expected_out [$];
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;
  bit calm = 1'b0;
  bit send_pause = 1'b0;

  const int sine_tab [17] = '{0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
                              25330, 27246, 28899, 30274, 31357, 32138, 32610, 32768};

  function automatic longint floor_shr(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint sine_gain(logic [23:0] p);
    longint q, idx, fr, a, b;
    q = (p < 24'h800000) ? p : 64'd16777216 - p;
    idx = q >> 19;
    fr = q & 64'h7FFFF;
    if (idx >= 16) return 32768;
    a = sine_tab[idx];
    b = sine_tab[idx + 1];
    return a + (((b - a) * fr) >>> 19);
  endfunction

  function automatic longint windowed_tap(logic [23:0] p);
    longint ph, d, top, rp, fr, sc, ip;
    int i0, i1;
    ph = up_mode ? 64'd16777216 - p : longint'(p);
    d = ph * (longint'(span) - 1);
    if (d > (longint'(DEPTH - 2) << 24)) d = longint'(DEPTH - 2) << 24;
    top = longint'(wr_pos) << 24;
    rp = (top >= d) ? top - d : top + (longint'(DEPTH) << 24) - d;
    fr = rp & 64'hFFFFFF;
    i0 = int'((rp >> 24) % DEPTH);
    i1 = (i0 + 1) % DEPTH;
    sc = longint'(echo_store[i0]) * (64'd16777216 - fr) + longint'(echo_store[i1]) * fr;
    ip = floor_shr(sc + 8388608, 24);
    return ip * sine_gain(p);
  endfunction

  function automatic logic [23:0] shift_sample(logic [23:0] x);
    longint acc, y;
    echo_store[wr_pos] = x;
    ph_a = ph_a + ph_step;
    ph_b = ph_b + ph_step;
    acc = windowed_tap(ph_a) + windowed_tap(ph_b);
    y = floor_shr(acc + 16384, 15);
    if (y > 8388607) y = 8388607;
    if (y < -8388608) y = -8388608;
    wr_pos = wr_pos + 1'b1;
    return y[23:0];
  endfunction

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [23:0] val);
    logic [14:0] v;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PHASE_INC: ph_step = val;
      REG_PITCH_UP:  up_mode = val[0];
      REG_SPAN: begin
        v = val[14:0];
        if (v < 64) v = 64;
        if (v > DEPTH) v = DEPTH;
        span = v;
      end
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_samples.size() != 0 || expected_out.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample(int mode);
    case (mode)
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return $urandom_range(1, 0) ? 24'(24'h7FF000 + $urandom_range(4095, 0))
                                     : 24'(24'h800000 + $urandom_range(4095, 0));
      default: return 24'($urandom());
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // driver
  bit in_flight = 1'b0;
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      expected_out.push_back(shift_sample(pending_samples.pop_front()));
      in_flight = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!in_flight && !s_tvalid) begin
      if (pending_samples.size() != 0 && !send_pause && (calm || $urandom_range(99, 0) >= 10)) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_samples[0];
        in_flight = 1'b1;
      end
    end else if (!in_flight && s_tvalid) begin
      if (pending_samples.size() != 0 && !send_pause && (calm || $urandom_range(99, 0) >= 10)) begin
        s_tdata <= pending_samples[0];
        in_flight = 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_out.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[23:0], 24'h0);
      end else begin
        logic [23:0] want;
        want = expected_out.pop_front();
        if (m_tdata[23:0] !== want) report_mismatch("result", m_tdata[23:0], want);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99, 0) >= 10);
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) echo_store[i] = '0;
    wr_pos = '0;
    ph_a = '0;
    ph_b = 24'h800000;
    ph_step = '0;
    up_mode = 1'b1;
    span = 15'd8192;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset settings, zero increment, extremes
    for (int i = 0; i < 6; i++) pending_samples.push_back(rand_sample(i % 2));
    drain();
    write_reg(REG_SPAN, 24'd3);
    write_reg(REG_PHASE_INC, 24'h000000);
    write_reg(REG_PITCH_UP, 24'd0);
    for (int i = 0; i < 6; i++) pending_samples.push_back(rand_sample(i % 3));
    drain();
    write_reg(REG_SPAN, 24'h7FFF);
    write_reg(REG_PITCH_UP, 24'd1);
    write_reg(REG_PHASE_INC, 24'hFFFFFF);
    write_reg(REG_UNUSED, 24'h123456);
    for (int i = 0; i < 8; i++) pending_samples.push_back(rand_sample(i % 3));
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_PHASE_INC, (ph % 3 == 0) ? 24'(($urandom() & 24'hFFFFFF)) :
                24'($urandom_range(400000, 0)));
      write_reg(REG_PITCH_UP, 24'($urandom()));
      write_reg(REG_SPAN, (ph == 4) ? 24'd16384 : (ph == 5) ? 24'd64 :
                24'($urandom_range(20000, 0)));
      for (int i = 0; i < 188; i++)
        pending_samples.push_back(rand_sample($urandom_range(9, 0) == 0 ?
                                  $urandom_range(2, 0) : 3));
      if (ph == 2) begin
        @(negedge clk);
        hold_off <= 300;
      end
      if (ph == 6) calm = 1'b1;
      if (ph == 7) calm = 1'b0;
      if (ph == 8) begin
        while (pending_samples.size() > 90) @(posedge clk);
        send_pause = 1'b1;
        while (expected_out.size() != 0) @(posedge clk);
        send_pause = 1'b0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
